// ----- rtl/lgg_pkg.sv -----
// shared types and codes for the life grid generation core
// no dependencies
`timescale 1ns / 1ps

package lgg_pkg;

   localparam logic CMD_TOGGLE  = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [2:0] target_row;
      logic [7:0] toggle_mask;
   } req_type;

   typedef struct packed {
      logic [2:0] out_row;
      logic [7:0] row_cells;
      logic       board_empty;
      logic       last_row;
   } rsp_type;

   // control handed from the sequencer to every row cell
   typedef struct packed {
      logic apply;
      logic advance;
      logic rotate;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_SEND
   } seq_state_type;

endpackage

// ----- rtl/life_grid_generation_core.sv -----
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | lgg_pkg::req_type (cmd, target_row, toggle_mask)
// rsp     | out | rsp_valid / rsp_stall | lgg_pkg::rsp_type (out_row, row_cells, flags)
// an item without stalls: the accept cycle applies the toggle to the target row or
// the generation in every row cell at once, the ST_SUM state latches the empty flag, then
// ROWS transfers, the row chain rotating one place per transfer back to its home order
// reset clears the board; a stall on rsp holds the chain and the current row
// top level: row cell chain plus sequencer, depends on lgg_pkg, lgg_cell, lgg_seq
`timescale 1ns / 1ps

module life_grid_generation_core #(
   parameter int ROWS = 8,
   parameter int COLS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lgg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lgg_pkg::rsp_type rsp_data
);
   import lgg_pkg::*;

   localparam int CNT_W = $clog2(ROWS);

   cell_ctl_type      ctl;
   logic [COLS-1:0]   row_q [ROWS];
   logic [ROWS-1:0]   nonzero;
   logic [COLS-1:0]   toggle_bits;
   logic [COLS+7:0]   mask_wide;
   logic [COLS+7:0]   head_wide;
   logic [CNT_W+2:0]  target_wide;

   assign mask_wide   = {{COLS{1'b0}}, req_data.toggle_mask};
   assign toggle_bits = mask_wide[COLS-1:0];
   assign target_wide = {{CNT_W{1'b0}}, req_data.target_row};
   assign head_wide   = {8'h00, row_q[0]};

   for (genvar k = 0; k < ROWS; k++) begin : g_row
      logic [COLS-1:0] above;
      logic [COLS-1:0] below;
      logic            hit;

      if (k == 0) begin : g_top
         assign above = '0;
      end else begin : g_mid_a
         assign above = row_q[k-1];
      end
      if (k == ROWS - 1) begin : g_bot
         assign below = '0;
      end else begin : g_mid_b
         assign below = row_q[k+1];
      end

      assign hit = target_wide == (CNT_W + 3)'(k);

      lgg_cell #(
         .COLS (COLS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .hit         (hit),
         .toggle_bits (toggle_bits),
         .above       (above),
         .below       (below),
         .next_in     (row_q[(k + 1) % ROWS]),
         .row_out     (row_q[k]),
         .nonzero     (nonzero[k])
      );
   end

   lgg_seq #(
      .ROWS (ROWS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_cmd       (req_data.cmd),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .board_nonzero (|nonzero),
      .ctl           (ctl),
      .out_row       (rsp_data.out_row),
      .board_empty   (rsp_data.board_empty),
      .last_row      (rsp_data.last_row)
   );

   assign rsp_data.row_cells = head_wide[7:0];

endmodule

// ----- rtl/lgg_cell.sv -----
// one board row: toggle, life rule against its neighbor rows, and rotation hop
// depends on lgg_pkg
`timescale 1ns / 1ps

module lgg_cell #(
   parameter int COLS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lgg_pkg::cell_ctl_type   ctl,
   input  logic                    hit,
   input  logic [COLS-1:0]         toggle_bits,
   input  logic [COLS-1:0]         above,
   input  logic [COLS-1:0]         below,
   input  logic [COLS-1:0]         next_in,
   output logic [COLS-1:0]         row_out,
   output logic                    nonzero
);
   import lgg_pkg::*;

   logic [COLS-1:0] row_ff;
   logic [COLS-1:0] row_in;
   logic [COLS-1:0] life_row;
   logic [COLS+1:0] pad_a;
   logic [COLS+1:0] pad_m;
   logic [COLS+1:0] pad_b;

   assign pad_a = {1'b0, above, 1'b0};
   assign pad_m = {1'b0, row_ff, 1'b0};
   assign pad_b = {1'b0, below, 1'b0};

   // pad bit c+1 is column c
   always_comb begin
      logic [3:0] n;
      for (int c = 0; c < COLS; c++) begin
         n = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
           + 4'(pad_m[c]) + 4'(pad_m[c+2])
           + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
         life_row[c] = (n == 4'd3) || ((n == 4'd2) && row_ff[c]);
      end
   end

   always_comb begin
      row_in = row_ff;
      priority if (ctl.rotate) begin
         row_in = next_in;
      end else if (ctl.apply && ctl.advance == CMD_ADVANCE) begin
         row_in = life_row;
      end else if (ctl.apply && hit) begin
         row_in = row_ff ^ toggle_bits;
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;
   assign nonzero = |row_ff;

endmodule

// ----- rtl/lgg_seq.sv -----
// sequencer: accepts items, latches the empty flag, counts the row transfers
// depends on lgg_pkg
`timescale 1ns / 1ps

module lgg_seq #(
   parameter int ROWS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  board_nonzero,
   output lgg_pkg::cell_ctl_type ctl,
   output logic [2:0]            out_row,
   output logic                  board_empty,
   output logic                  last_row
);
   import lgg_pkg::*;

   localparam int CNT_W = $clog2(ROWS);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             empty_ff, empty_in;
   logic             req_xfer;
   logic             rsp_xfer;
   logic             at_last;
   logic [CNT_W+2:0] count_wide;

   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign at_last    = count_ff == CNT_W'(ROWS - 1);
   assign count_wide = {3'b000, count_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_xfer && at_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SUM: begin
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      empty_in = empty_ff;
      if (req_xfer) count_in = '0;
      else if (rsp_xfer) count_in = count_ff + 1'b1;
      if (state_ff == ST_SUM) empty_in = !board_nonzero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         empty_ff <= empty_in;
      end
   end

   assign ctl.apply   = req_xfer;
   assign ctl.advance = req_cmd;
   assign ctl.rotate  = rsp_xfer;

   assign out_row     = count_wide[2:0];
   assign board_empty = empty_ff;
   assign last_row    = at_last;

endmodule

// ----- rtl/lgg_checker.sv -----
// port-level checks for the life grid generation core, with its bind
// depends on lgg_pkg and life_grid_generation_core
`timescale 1ns / 1ps

module lgg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lgg_pkg::rsp_type rsp_data
);
   import lgg_pkg::*;

   logic req_xfer;
   logic rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp changed");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req open while report pending");

   // no result in the cycle after an accepted item
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !rsp_valid && req_stall)
      else $error("report began too early");

   // rows count up with a steady empty flag
   a_next_row: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_data.last_row |=> rsp_valid
         && rsp_data.out_row == $past(rsp_data.out_row) + 3'd1
         && rsp_data.board_empty == $past(rsp_data.board_empty))
      else $error("row sequence broken");

   // report ends on the last row
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_data.last_row |=> !rsp_valid)
      else $error("report ran past last row");

endmodule

bind life_grid_generation_core lgg_checker u_lgg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
